// ===== rtl/core/awu_pkg.sv =====
package awu_pkg;

    // Field widths of one beat on either channel.
    localparam int IDX_W = 10;
    localparam int VAL_W = 48;

    // Item kinds.
    localparam logic KIND_ANCHOR = 1'b0;
    localparam logic KIND_GRAD   = 1'b1;

    // Configuration register indexes (byte address divided by four).
    localparam logic [2:0] REG_LR    = 3'd0;
    localparam logic [2:0] REG_BETA1 = 3'd1;
    localparam logic [2:0] REG_BETA2 = 3'd2;
    localparam logic [2:0] REG_EPS   = 3'd3;
    localparam logic [2:0] REG_TRUST = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [23:0] LR_RST    = 24'h010000;
    localparam logic [23:0] BETA1_RST = 24'hE66666;
    localparam logic [23:0] BETA2_RST = 24'hFFBE77;
    localparam logic [31:0] EPS_RST   = 32'h002AF31E;
    localparam logic [31:0] TRUST_RST = 32'h001E0000;

    // One in Q0.24.
    localparam logic [24:0] ONE24 = 25'h1000000;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    end_of_pass;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        weight_index;
        logic signed [VAL_W-1:0] new_weight;
        logic [VAL_W-1:0]        max_drift;
        logic                    over_trust;
        logic                    pass_done;
    } t_out_item;

    // An accepted item with its store address already reduced.
    typedef struct packed {
        t_in_item         item;
        logic [IDX_W-1:0] addr;
    } t_job;

    // Configuration as seen by the update engine.
    typedef struct packed {
        logic [23:0] lr;
        logic [23:0] beta1;
        logic [23:0] beta2;
        logic [31:0] eps;
        logic [31:0] trust;
        logic        beta1_wr;
        logic        beta2_wr;
    } t_cfg;

endpackage

// ===== rtl/core/awu_ram.sv =====
module awu_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/awu_front.sv =====
module awu_front #(
    parameter int NUM_WEIGHTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  awu_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output awu_pkg::t_job     o_job
);
    import awu_pkg::*;

    localparam logic [16:0] NW        = 17'(NUM_WEIGHTS);
    localparam logic [1:0]  LAST_STEP = 2'd2;
    // Scaled reciprocal of the depth; an index never reaches a depth of 1024 or more.
    localparam logic [20:0] RECIP =
        21'((NUM_WEIGHTS >= 1024) ? 0 : ((1 << 20) / NUM_WEIGHTS));

    logic             r_active;
    logic [1:0]       r_cnt;
    t_in_item         r_item;
    logic [IDX_W-1:0] r_quo;
    logic [IDX_W-1:0] r_rem;
    logic [30:0]      prod;
    logic [16:0]      rem_est;
    logic             rem_ge;
    logic             done;

    // The reciprocal estimate of the quotient is exact or one short, so one
    // compare and subtract finishes the remainder modulo the store depth.
    assign prod    = 31'(r_item.index) * 31'(RECIP);
    assign rem_est = 17'(r_item.index) - 17'(r_quo) * NW;
    assign rem_ge  = rem_est >= NW;
    assign done    = r_cnt == LAST_STEP;
    assign o_push  = r_active && done && !i_full;
    assign busy    = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (start && !r_active) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (r_active && !done) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (o_push) begin
            r_active <= 1'b0;
        end
    end

    // The quotient estimate is registered first, then the remainder.
    always_ff @(posedge i_clk) begin
        if (start && !r_active) begin
            r_item <= i_item;
        end else if (r_active && r_cnt == 2'd0) begin
            r_quo <= prod[29:20];
        end else if (r_active && r_cnt == 2'd1) begin
            r_rem <= rem_ge ? IDX_W'(rem_est - NW) : IDX_W'(rem_est);
        end
    end

    assign o_job.item = r_item;
    assign o_job.addr = r_rem;

endmodule

// ===== rtl/core/awu_fifo.sv =====
module awu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  awu_pkg::t_job i_job,
    input  logic          i_pop,
    output awu_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);
    import awu_pkg::*;

    t_job       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_empty = r_cnt == 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_job   = r_slot[r_rp];

    // Two-entry queue between the front and the update engine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

// ===== rtl/core/awu_back.sv =====
module awu_back #(
    parameter int NUM_WEIGHTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  awu_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  awu_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_valid,
    output awu_pkg::t_out_item o_result
);
    import awu_pkg::*;

    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_FMOM  = 4'd5;
    localparam logic [3:0] S_VDEC  = 4'd6;
    localparam logic [3:0] S_GSQ   = 4'd7;
    localparam logic [3:0] S_VNEW  = 4'd8;
    localparam logic [3:0] S_ROOT  = 4'd9;
    localparam logic [3:0] S_DEN   = 4'd10;
    localparam logic [3:0] S_SCALE = 4'd11;
    localparam logic [3:0] S_NORM  = 4'd12;
    localparam logic [3:0] S_UPD   = 4'd13;

    localparam logic [6:0] MUL_LAST = 7'd3;
    localparam logic [6:0] DIV_LAST = 7'd127;
    localparam logic [6:0] SQ_LAST  = 7'd59;

    localparam logic [47:0] W_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] W_MIN = 48'h8000_0000_0000;
    localparam logic [127:0] STEP_CAP = 128'h1_0000_0000_0000;

    function automatic logic [47:0] sat48(input logic [51:0] x);
        logic [47:0] r;
        if (x[51] && x[50:47] != 4'hF) begin
            r = W_MIN;
        end else if (!x[51] && x[50:47] != 4'h0) begin
            r = W_MAX;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

    // Control state.
    logic [3:0]  r_state;
    logic [3:0]  r_ret;
    logic [6:0]  r_cnt;
    logic        r_valid;
    logic [23:0] r_p1;
    logic [23:0] r_p2;
    logic [47:0] r_dmax;

    // Operands of the item under way.
    t_job        r_job;
    t_out_item   r_res;
    logic [47:0] r_w;
    logic [47:0] r_anc;
    logic [47:0] r_m;
    logic [63:0] r_v;
    logic        r_neg;
    logic [47:0] r_mnew;
    logic [63:0] r_vacc;
    logic [63:0] r_den;

    // Shared multiplier, divider and square root unit registers.
    logic [63:0]  r_mul_a;
    logic [63:0]  r_mul_b;
    logic [127:0] r_mul_acc;
    logic [127:0] r_div_n;
    logic [63:0]  r_div_d;
    logic [63:0]  r_div_r;
    logic [119:0] r_sq_x;
    logic [63:0]  r_sq_r;
    logic [59:0]  r_sq_root;

    // Store ports.
    logic [47:0] w_rd, a_rd, m_rd;
    logic [63:0] v_rd;
    logic        w_we, a_we, m_we, v_we;
    logic [47:0] w_wd, m_wd;
    logic [63:0] v_wd;
    logic [AW-1:0] waddr, raddr;
    logic        pop_anchor;

    // Datapath nets.
    logic [48:0]  gm_diff;
    logic [48:0]  gm_mag;
    logic [103:0] rnd_acc;
    logic [51:0]  m_sum;
    logic [47:0]  g_mag;
    logic [47:0]  m_mag;
    logic [63:0]  g2;
    logic [65:0]  v_sum;
    logic [63:0]  v_new;
    logic [63:0]  den;
    logic [48:0]  step;
    logic [51:0]  w_sum;
    logic [47:0]  w_new;
    logic [48:0]  drift_s;
    logic [47:0]  drift;
    logic [47:0]  max_new;
    logic [47:0]  trust_q;
    logic [48:0]  p1_prod;
    logic [48:0]  p2_prod;
    logic [79:0]  mul_pp;
    logic [144:0] mul_sum;
    logic [64:0]  div_rem2;
    logic         div_ge;
    logic [65:0]  sq_rem2;
    logic [61:0]  sq_trial;
    logic         sq_ge;

    awu_ram #(.WIDTH(48), .DEPTH(NUM_WEIGHTS)) u_weight (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(waddr), .i_wdata(w_wd),
        .i_raddr(raddr), .o_rdata(w_rd)
    );
    awu_ram #(.WIDTH(48), .DEPTH(NUM_WEIGHTS)) u_anchor (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(waddr), .i_wdata(i_job.item.value),
        .i_raddr(raddr), .o_rdata(a_rd)
    );
    awu_ram #(.WIDTH(48), .DEPTH(NUM_WEIGHTS)) u_mom1 (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(waddr), .i_wdata(m_wd),
        .i_raddr(raddr), .o_rdata(m_rd)
    );
    awu_ram #(.WIDTH(64), .DEPTH(NUM_WEIGHTS)) u_mom2 (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(waddr), .i_wdata(v_wd),
        .i_raddr(raddr), .o_rdata(v_rd)
    );

    // Store access: an anchor is written as it leaves the queue.
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign pop_anchor = o_pop && (i_job.item.kind == KIND_ANCHOR);
    assign raddr      = AW'(i_job.addr);
    assign waddr      = (r_state == S_IDLE) ? AW'(i_job.addr) : AW'(r_job.addr);
    assign w_we       = pop_anchor || (r_state == S_UPD);
    assign a_we       = pop_anchor;
    assign m_we       = pop_anchor || (r_state == S_VNEW);
    assign v_we       = pop_anchor || (r_state == S_VNEW);
    assign w_wd       = pop_anchor ? i_job.item.value : w_new;
    assign m_wd       = pop_anchor ? 48'd0 : r_mnew;
    assign v_wd       = pop_anchor ? 64'd0 : v_new;

    // Moment and step arithmetic, one piece per sequencer state.
    always_comb begin
        gm_diff = {r_job.item.value[47], r_job.item.value} - {m_rd[47], m_rd};
        gm_mag  = gm_diff[48] ? (49'd0 - gm_diff) : gm_diff;
        rnd_acc = 104'((r_mul_acc + 128'd8388608) >> 24);
        m_sum   = {{4{r_m[47]}}, r_m} +
                  (r_neg ? (52'd0 - {2'b0, rnd_acc[49:0]}) : {2'b0, rnd_acc[49:0]});
        g_mag   = r_job.item.value[47] ? (48'd0 - r_job.item.value) : r_job.item.value;
        m_mag   = r_mnew[47] ? (48'd0 - r_mnew) : r_mnew;
        g2      = (r_mul_acc[127:88] != 40'd0) ? '1 : r_mul_acc[87:24];
        v_sum   = {2'b0, r_vacc} + rnd_acc[65:0];
        v_new   = (v_sum[65:64] != 2'd0) ? '1 : v_sum[63:0];
        den     = {4'd0, r_sq_root} + {32'd0, i_cfg.eps};
        step    = (r_div_n > STEP_CAP) ? STEP_CAP[48:0] : r_div_n[48:0];
        w_sum   = r_mnew[47] ? ({{4{r_w[47]}}, r_w} + {3'b0, step})
                             : ({{4{r_w[47]}}, r_w} - {3'b0, step});
        w_new   = sat48(w_sum);
        drift_s = {w_new[47], w_new} - {r_anc[47], r_anc};
        drift   = drift_s[48] ? 48'(49'd0 - drift_s) : drift_s[47:0];
        max_new = (drift > r_dmax) ? drift : r_dmax;
        trust_q = {8'd0, i_cfg.trust, 8'd0};
        p1_prod = {1'b0, 48'(r_p1) * 48'(i_cfg.beta1)} + 49'd8388608;
        p2_prod = {1'b0, 48'(r_p2) * 48'(i_cfg.beta2)} + 49'd8388608;
    end

    // One 64 by 16 partial product per cycle, accumulated from the right.
    assign mul_pp  = 80'(r_mul_a) * 80'(r_mul_b[15:0]);
    assign mul_sum = {17'd0, r_mul_acc} + {1'b0, mul_pp, 64'd0};

    // Restoring divider, one quotient bit per cycle.
    assign div_rem2 = {r_div_r, r_div_n[127]};
    assign div_ge   = div_rem2 >= {1'b0, r_div_d};

    // Digit-by-digit square root, one root bit per cycle.
    assign sq_rem2  = {r_sq_r, r_sq_x[119:118]};
    assign sq_trial = {r_sq_root, 2'b01};
    assign sq_ge    = sq_rem2 >= {4'd0, sq_trial};

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
            r_p1    <= BETA1_RST;
            r_p2    <= BETA2_RST;
            r_dmax  <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg.beta1_wr) begin
                r_p1 <= i_cfg.beta1;
            end
            if (i_cfg.beta2_wr) begin
                r_p2 <= i_cfg.beta2;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_job.item.kind == KIND_GRAD) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_valid <= 1'b1;
                            if (i_job.item.end_of_pass) begin
                                r_p1   <= i_cfg.beta1;
                                r_p2   <= i_cfg.beta2;
                                r_dmax <= '0;
                            end
                        end
                    end
                end
                S_LOAD, S_FMOM, S_VDEC, S_GSQ: begin
                    r_state <= S_MUL;
                    r_cnt   <= '0;
                    case (r_state)
                        S_LOAD:  r_ret <= S_FMOM;
                        S_FMOM:  r_ret <= S_VDEC;
                        S_VDEC:  r_ret <= S_GSQ;
                        default: r_ret <= S_VNEW;
                    endcase
                end
                S_VNEW, S_SCALE, S_NORM: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                    case (r_state)
                        S_VNEW:  r_ret <= S_ROOT;
                        S_SCALE: r_ret <= S_NORM;
                        default: r_ret <= S_UPD;
                    endcase
                end
                S_ROOT: begin
                    r_state <= S_SQRT;
                    r_cnt   <= '0;
                    r_ret   <= S_DEN;
                end
                S_DEN: begin
                    r_cnt <= '0;
                    if (den == 64'd0) begin
                        r_state <= S_UPD;
                    end else begin
                        r_state <= S_MUL;
                        r_ret   <= S_SCALE;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == MUL_LAST) begin
                        r_state <= r_ret;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= r_ret;
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == SQ_LAST) begin
                        r_state <= r_ret;
                    end
                end
                S_UPD: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_job.item.end_of_pass) begin
                        r_dmax <= '0;
                        r_p1   <= p1_prod[47:24];
                        r_p2   <= p2_prod[47:24];
                    end else begin
                        r_dmax <= max_new;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    r_job                 <= i_job;
                    r_res.weight_index    <= i_job.item.index;
                    r_res.new_weight      <= i_job.item.value;
                    r_res.max_drift       <= r_dmax;
                    r_res.over_trust      <= r_dmax >= trust_q;
                    r_res.pass_done       <= i_job.item.end_of_pass;
                end
            end
            S_LOAD: begin
                r_w       <= w_rd;
                r_anc     <= a_rd;
                r_m       <= m_rd;
                r_v       <= v_rd;
                r_neg     <= gm_diff[48];
                r_mul_a   <= 64'(gm_mag);
                r_mul_b   <= 64'(ONE24 - {1'b0, i_cfg.beta1});
                r_mul_acc <= '0;
            end
            S_FMOM: begin
                r_mnew    <= sat48(m_sum);
                r_mul_a   <= r_v;
                r_mul_b   <= 64'(i_cfg.beta2);
                r_mul_acc <= '0;
            end
            S_VDEC: begin
                r_vacc    <= rnd_acc[63:0];
                r_mul_a   <= 64'(g_mag);
                r_mul_b   <= 64'(g_mag);
                r_mul_acc <= '0;
            end
            S_GSQ: begin
                r_mul_a   <= g2;
                r_mul_b   <= 64'(ONE24 - {1'b0, i_cfg.beta2});
                r_mul_acc <= '0;
            end
            S_VNEW: begin
                r_div_n <= {8'd0, v_new, 56'd0};
                r_div_d <= 64'(ONE24 - {1'b0, r_p2});
                r_div_r <= '0;
            end
            S_ROOT: begin
                r_sq_x    <= r_div_n[119:0];
                r_sq_r    <= '0;
                r_sq_root <= '0;
            end
            S_DEN: begin
                r_den     <= den;
                r_div_n   <= '0;
                r_mul_a   <= 64'(m_mag);
                r_mul_b   <= 64'(i_cfg.lr);
                r_mul_acc <= '0;
            end
            S_SCALE: begin
                r_div_n <= {r_mul_acc[91:0], 36'd0};
                r_div_d <= 64'(ONE24 - {1'b0, r_p1});
                r_div_r <= '0;
            end
            S_NORM: begin
                r_div_d <= r_den;
                r_div_r <= '0;
            end
            S_MUL: begin
                r_mul_acc <= mul_sum[143:16];
                r_mul_b   <= {16'd0, r_mul_b[63:16]};
            end
            S_DIV: begin
                r_div_r <= div_ge ? 64'(div_rem2 - {1'b0, r_div_d}) : div_rem2[63:0];
                r_div_n <= {r_div_n[126:0], div_ge};
            end
            S_SQRT: begin
                r_sq_r    <= sq_ge ? 64'(sq_rem2 - {4'd0, sq_trial}) : sq_rem2[63:0];
                r_sq_root <= {r_sq_root[58:0], sq_ge};
                r_sq_x    <= {r_sq_x[117:0], 2'b00};
            end
            S_UPD: begin
                r_res.weight_index <= r_job.item.index;
                r_res.new_weight   <= w_new;
                r_res.max_drift    <= max_new;
                r_res.over_trust   <= max_new >= trust_q;
                r_res.pass_done    <= r_job.item.end_of_pass;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/core/adam_weight_update.sv =====
// Per-weight Adam update engine.
// Items enter on the command channel: an item is taken at a clock edge where
// start is high and busy is low. An anchor item loads a weight, records it as
// the anchor and clears its moments; a gradient item updates both moments and
// applies the bias-corrected step. Every item yields exactly one result beat,
// shown on o_result for a single cycle while o_valid is high. The receiver
// cannot stall the block, so results are never held back.
// The front takes an item and reduces its index modulo the store depth,
// then places it in a two-entry queue; it can take the next item while the
// engine works. An anchor item's result appears in the cycle after the item
// leaves the queue. A gradient item then passes three 128-step divisions and
// a 60-step square root on shared iterative units, five multiplications of
// four partial products each and ten sequencing steps; a zero denominator
// skips the last multiplication, the last two divisions and two of the steps.
// Reset clears the queue and the running drift maximum, sets the step powers
// to the reset betas and restores the register defaults; the weight, anchor
// and moment stores hold nothing valid until an anchor item writes an entry.
// Configuration sits on an APB port at byte addresses 0 through 16.
module adam_weight_update #(
    parameter int NUM_WEIGHTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  awu_pkg::t_in_item  i_item,
    output logic               o_valid,
    output awu_pkg::t_out_item o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import awu_pkg::*;

    logic [23:0] r_lr, r_b1, r_b2;
    logic [31:0] r_eps, r_trust;
    logic        r_b1_wr, r_b2_wr;
    logic        cfg_wr;
    logic [2:0]  reg_sel;
    t_cfg        cfg;
    t_job        front_job, head_job;
    logic        push, pop, q_empty, q_full;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];

    // Register writes; a beta write also restarts its power the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr    <= LR_RST;
            r_b1    <= BETA1_RST;
            r_b2    <= BETA2_RST;
            r_eps   <= EPS_RST;
            r_trust <= TRUST_RST;
            r_b1_wr <= 1'b0;
            r_b2_wr <= 1'b0;
        end else begin
            r_b1_wr <= cfg_wr && (reg_sel == REG_BETA1);
            r_b2_wr <= cfg_wr && (reg_sel == REG_BETA2);
            if (cfg_wr) begin
                case (reg_sel)
                    REG_LR:    r_lr    <= pwdata[23:0];
                    REG_BETA1: r_b1    <= pwdata[23:0];
                    REG_BETA2: r_b2    <= pwdata[23:0];
                    REG_EPS:   r_eps   <= pwdata;
                    REG_TRUST: r_trust <= pwdata;
                    default:   r_lr    <= r_lr;
                endcase
            end
        end
    end

    // Register reads.
    always_comb begin
        case (reg_sel)
            REG_LR:    prdata = {8'd0, r_lr};
            REG_BETA1: prdata = {8'd0, r_b1};
            REG_BETA2: prdata = {8'd0, r_b2};
            REG_EPS:   prdata = r_eps;
            REG_TRUST: prdata = r_trust;
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.lr       = r_lr;
    assign cfg.beta1    = r_b1;
    assign cfg.beta2    = r_b2;
    assign cfg.eps      = r_eps;
    assign cfg.trust    = r_trust;
    assign cfg.beta1_wr = r_b1_wr;
    assign cfg.beta2_wr = r_b2_wr;

    awu_front #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_full(q_full), .o_push(push), .o_job(front_job)
    );

    awu_fifo u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(front_job),
        .i_pop(pop), .o_job(head_job), .o_empty(q_empty), .o_full(q_full)
    );

    awu_back #(.NUM_WEIGHTS(NUM_WEIGHTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_empty(q_empty),
        .i_job(head_job), .o_pop(pop), .o_valid(o_valid), .o_result(o_result)
    );

endmodule
